// ----- sv/noc_flit_injector_abp_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the flit injector
// Concurrent checks on the rising clock edge, masked while reset is held.
// ----------------------------------------------------------------------------
`ifndef NOC_FLIT_INJECTOR_ABP_CORE_ASSERT_SVH
`define NOC_FLIT_INJECTOR_ABP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge out of reset.
`define NFI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("nfi assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define NFI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nfi assertion failed");

// An antecedent that implies a consequent in the next cycle.
`define NFI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nfi assertion failed");

`else

`define NFI_ASSERT(lbl, prop)
`define NFI_ASSERT_IMPL(lbl, ante, cons)
`define NFI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/nfi_abp_pkg.sv -----
// ----------------------------------------------------------------------------
// Flit injector package
// Field widths, flit type codes and the packet queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package nfi_abp_pkg;

    // Field widths of one item.
    localparam int unsigned ID_W   = 8;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned SEQ_W  = 6;
    localparam int unsigned KIND_W = 2;

    // Packed stream widths.
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned S_USER_W = 1;
    localparam int unsigned M_DATA_W = 64;
    localparam int unsigned M_USER_W = 3;

    // Longest packet in flits; longer offers are cut to this length.
    localparam int unsigned MAX_PACKET_FLITS = 64;

    // Flit type carried with every sent flit.
    typedef enum logic [KIND_W-1:0] {
        FLIT_HEAD = 2'd0,
        FLIT_BODY = 2'd1,
        FLIT_TAIL = 2'd2
    } t_flit_kind;

    // One queued packet.
    typedef struct packed {
        logic [ID_W-1:0]   src;
        logic [ID_W-1:0]   dst;
        logic [TIME_W-1:0] stamp;
        logic [SIZE_W-1:0] size;
    } t_pkt_entry;

endpackage

`default_nettype wire

// ----- sv/noc_flit_injector_abp_core.sv -----
// ----------------------------------------------------------------------------
// Network interface flit injector, alternating bit handshake
// Queues offered packets and sends one flit per cycle when the router's
// acknowledge level matches the transmit level, unless results are stalled.
// ----------------------------------------------------------------------------
// Each input item is one cycle of the network interface and gives exactly one
// result item. The block takes one item every clock while results are taken;
// an accepted item is held in the input register, and its result is loaded
// into the result register once that register is free or being emptied. A
// result that waits for the receiver holds the input side. Per item the queue
// update, the front packet lookup and the flit build are one pass of logic.
// Packets wait in a queue of QUEUE_DEPTH entries held in a memory whose read
// port is registered: it always holds the entry at the queue head for the next
// item, with the same-cycle write forwarded.
`default_nettype none

module noc_flit_injector_abp_core #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Slave side.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: pkt_src[7:0], pkt_dst[15:8], pkt_time[47:16], pkt_size[54:48],
    //        ack_in[55], req_in[56], zero fill[63:57]
    input  wire logic [nfi_abp_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: pkt_valid[0]
    input  wire logic [nfi_abp_pkg::S_USER_W-1:0]   s_tuser,
    // Master side.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: flit_src[7:0], flit_dst[15:8], flit_time[47:16], flit_seq[53:48],
    //        req_out[54], ack_out[55], pkt_dropped[56], zero fill[63:57]
    output logic [nfi_abp_pkg::M_DATA_W-1:0]        m_tdata,
    // tuser: flit_valid[0], flit_kind[2:1]
    output logic [nfi_abp_pkg::M_USER_W-1:0]        m_tuser
);

    `include "noc_flit_injector_abp_core_assert.svh"

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SZ_W  = nfi_abp_pkg::SIZE_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Input register.
    logic                               r_in_valid;
    logic [nfi_abp_pkg::S_DATA_W-1:0]   r_in_data;
    logic [nfi_abp_pkg::S_USER_W-1:0]   r_in_user;

    // Result register.
    logic                               r_out_valid;
    logic [nfi_abp_pkg::M_DATA_W-1:0]   r_out_data;
    logic [nfi_abp_pkg::M_USER_W-1:0]   r_out_user;

    // Queue and handshake state.
    logic [PTR_W-1:0]   r_q_head;
    logic [PTR_W-1:0]   r_q_tail;
    logic [CNT_W-1:0]   r_q_count;
    logic [SZ_W-1:0]    r_flits_sent;
    logic               r_tx_level;
    logic               r_rx_level;

    // Packet memory and its registered read port.
    nfi_abp_pkg::t_pkt_entry r_pkt_mem [QUEUE_DEPTH];
    nfi_abp_pkg::t_pkt_entry r_rd_entry;

    logic [PTR_W-1:0]   n_q_head;
    logic [PTR_W-1:0]   n_q_tail;
    logic [CNT_W-1:0]   n_q_count;
    logic [SZ_W-1:0]    n_flits_sent;
    logic               n_tx_level;
    logic               n_rx_level;
    logic [nfi_abp_pkg::M_DATA_W-1:0]   n_out_data;
    logic [nfi_abp_pkg::M_USER_W-1:0]   n_out_user;

    logic                       advance;
    logic                       in_pkt_valid;
    logic                       in_ack;
    logic                       in_req;
    logic [SZ_W-1:0]            in_size;
    logic [SZ_W-1:0]            fixed_size;
    nfi_abp_pkg::t_pkt_entry    new_entry;
    nfi_abp_pkg::t_pkt_entry    front;
    logic                       q_full;
    logic                       drop;
    logic                       wr_en;
    logic [CNT_W-1:0]           count_wr;
    logic                       send;
    logic                       last_flit;
    logic [SZ_W:0]              sent_plus1;
    nfi_abp_pkg::t_flit_kind    kind;
    logic [PTR_W-1:0]           head_wrap;
    logic [PTR_W-1:0]           tail_wrap;
    logic [PTR_W-1:0]           rd_addr;

    // Handshake: the item in the input register moves on when the result
    // register is free or being emptied.
    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

    // Unpack the registered item.
    assign in_pkt_valid = r_in_user[0];
    assign in_size      = r_in_data[54:48];
    assign in_ack       = r_in_data[55];
    assign in_req       = r_in_data[56];

    // Size zero becomes one flit; oversize saturates.
    always_comb begin
        fixed_size = in_size;
        if (in_size == '0) begin
            fixed_size = SZ_W'(1);
        end else if (32'(in_size) > nfi_abp_pkg::MAX_PACKET_FLITS) begin
            fixed_size = SZ_W'(nfi_abp_pkg::MAX_PACKET_FLITS);
        end
    end

    assign new_entry.src   = r_in_data[7:0];
    assign new_entry.dst   = r_in_data[15:8];
    assign new_entry.stamp = r_in_data[47:16];
    assign new_entry.size  = fixed_size;

    // Queue admission.
    assign q_full   = (r_q_count == CNT_FULL);
    assign drop     = in_pkt_valid && q_full;
    assign wr_en    = in_pkt_valid && !q_full;
    assign count_wr = r_q_count + CNT_W'(wr_en);

    assign head_wrap = (r_q_head == PTR_LAST) ? '0 : r_q_head + PTR_W'(1);
    assign tail_wrap = (r_q_tail == PTR_LAST) ? '0 : r_q_tail + PTR_W'(1);

    // Front packet: an empty queue takes the packet queued in this cycle.
    assign front = (r_q_count == '0) ? new_entry : r_rd_entry;

    // Flit send decision and type.
    assign send       = (in_ack == r_tx_level) && (count_wr != '0);
    assign sent_plus1 = {1'b0, r_flits_sent} + (SZ_W+1)'(1);
    assign last_flit  = sent_plus1 >= {1'b0, front.size};

    always_comb begin
        if (r_flits_sent == '0) begin
            kind = nfi_abp_pkg::FLIT_HEAD;
        end else if (last_flit) begin
            kind = nfi_abp_pkg::FLIT_TAIL;
        end else begin
            kind = nfi_abp_pkg::FLIT_BODY;
        end
    end

    // Next state after this item.
    always_comb begin
        n_q_tail     = wr_en ? tail_wrap : r_q_tail;
        n_q_head     = r_q_head;
        n_q_count    = count_wr;
        n_flits_sent = r_flits_sent;
        n_tx_level   = r_tx_level ^ send;
        n_rx_level   = in_req;
        if (send) begin
            if (last_flit) begin
                n_flits_sent = '0;
                n_q_head     = head_wrap;
                n_q_count    = count_wr - CNT_W'(1);
            end else begin
                n_flits_sent = sent_plus1[SZ_W-1:0];
            end
        end
    end

    // Result item; flit fields stay zero when nothing is sent.
    always_comb begin
        n_out_data        = '0;
        n_out_user        = '0;
        n_out_data[54]    = n_tx_level;
        n_out_data[55]    = n_rx_level;
        n_out_data[56]    = drop;
        if (send) begin
            n_out_data[7:0]   = front.src;
            n_out_data[15:8]  = front.dst;
            n_out_data[47:16] = front.stamp;
            n_out_data[53:48] = r_flits_sent[nfi_abp_pkg::SEQ_W-1:0];
            n_out_user[0]     = 1'b1;
            n_out_user[2:1]   = kind;
        end
    end

    // Read address tracks the head as it stands after this cycle.
    assign rd_addr = advance ? n_q_head : r_q_head;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_q_head     <= '0;
            r_q_tail     <= '0;
            r_q_count    <= '0;
            r_flits_sent <= '0;
            r_tx_level   <= 1'b0;
            r_rx_level   <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_q_head     <= n_q_head;
                r_q_tail     <= n_q_tail;
                r_q_count    <= n_q_count;
                r_flits_sent <= n_flits_sent;
                r_tx_level   <= n_tx_level;
                r_rx_level   <= n_rx_level;
            end else if (m_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_data <= s_tdata;
            r_in_user <= s_tuser;
        end
        if (advance) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    // Packet memory: one write port, one registered read port with
    // forwarding of a write to the address being read.
    always_ff @(posedge i_clk) begin
        if (advance && wr_en) begin
            r_pkt_mem[r_q_tail] <= new_entry;
        end
        if (advance && wr_en && (r_q_tail == rd_addr)) begin
            r_rd_entry <= new_entry;
        end else begin
            r_rd_entry <= r_pkt_mem[rd_addr];
        end
    end

    // Checks.
    `NFI_ASSERT(a_count_bound, r_q_count <= CNT_FULL)
    `NFI_ASSERT_IMPL(a_mid_packet_queued, r_flits_sent != '0, r_q_count != '0)
    `NFI_ASSERT_IMPL(a_drop_only_full, advance && drop, r_q_count == CNT_FULL)
    `NFI_ASSERT_IMPL(a_tail_not_first, m_tvalid && m_tuser[0] && (m_tuser[2:1] == nfi_abp_pkg::FLIT_TAIL), m_tdata[53:48] != '0)
    `NFI_ASSERT_NEXT(a_send_toggles, advance && send, r_tx_level != $past(r_tx_level))

endmodule

`default_nettype wire

// ----- tb/sv/tb_noc_flit_injector_abp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the network interface flit injector
// Drives one interface cycle per input item and predicts the packet queue,
// the flit sequencing and both alternating bit levels. Each result item is
// compared field by field with the oldest prediction. Both stream sides idle
// in random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_noc_flit_injector_abp_core;

    localparam int unsigned QDEPTH        = 16;
    localparam int unsigned RANDOM_CYCLES = 1000;
    localparam int unsigned CALM_TAIL     = 150;
    localparam int unsigned LONG_HOLD     = 150;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // How the router's acknowledge level is chosen when an item goes out.
    typedef enum logic [1:0] {
        ACK_MATCH,
        ACK_MISMATCH,
        ACK_AS_GIVEN
    } t_ack_policy;

    // One cycle of the network interface as offered on the input stream.
    typedef struct {
        logic                                pkt_valid;
        logic [nfi_abp_pkg::ID_W-1:0]        src;
        logic [nfi_abp_pkg::ID_W-1:0]        dst;
        logic [nfi_abp_pkg::TIME_W-1:0]      stamp;
        logic [nfi_abp_pkg::SIZE_W-1:0]      size;
        logic                                ack;
        logic                                req;
        t_ack_policy                         ack_policy;
        logic                                wait_drain;
    } t_ni_cycle;

    // What the interface reports for one cycle.
    typedef struct {
        logic                                flit_valid;
        logic [nfi_abp_pkg::ID_W-1:0]        src;
        logic [nfi_abp_pkg::ID_W-1:0]        dst;
        logic [nfi_abp_pkg::TIME_W-1:0]      stamp;
        logic [nfi_abp_pkg::SEQ_W-1:0]       seq;
        logic [nfi_abp_pkg::KIND_W-1:0]      kind;
        logic                                req_out;
        logic                                ack_out;
        logic                                dropped;
    } t_ni_result;

    logic                              i_clk    = 1'b0;
    logic                              i_rst_n  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [nfi_abp_pkg::S_DATA_W-1:0]  s_tdata  = '0;
    logic [nfi_abp_pkg::S_USER_W-1:0]  s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [nfi_abp_pkg::M_DATA_W-1:0]  m_tdata;
    logic [nfi_abp_pkg::M_USER_W-1:0]  m_tuser;

    // Shadow of the packet queue and the handshake levels.
    nfi_abp_pkg::t_pkt_entry  pq_store [QDEPTH];
    int unsigned pq_head    = 0;
    int unsigned pq_tail    = 0;
    int unsigned pq_count   = 0;
    int unsigned flits_sent = 0;
    logic        tx_lvl     = 1'b0;
    logic        rx_lvl     = 1'b0;

    t_ni_cycle   pending_cycles [$];
    t_ni_result  expected_outputs [$];
    t_ni_cycle   on_bus;
    t_ni_result  got;
    t_ni_result  want;

    int unsigned n_total    = 0;
    int unsigned n_loaded   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_cycles   = 0;
    int unsigned src_gap    = 0;
    int unsigned sink_gap   = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    noc_flit_injector_abp_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // A cycle with no offer and levels at zero.
    function automatic t_ni_cycle quiet_cycle();
        t_ni_cycle c;
        c.pkt_valid  = 1'b0;
        c.src        = '0;
        c.dst        = '0;
        c.stamp      = '0;
        c.size       = '0;
        c.ack        = 1'b0;
        c.req        = 1'b0;
        c.ack_policy = ACK_AS_GIVEN;
        c.wait_drain = 1'b0;
        return c;
    endfunction

    // Idling runs in stretches of 128 items, two on and one off, and stops near the end.
    function automatic bit idling_allowed();
        return (n_loaded + CALM_TAIL < n_total) && ((n_loaded / 128) % 3 != 2);
    endfunction

    // Advance the interface by one cycle: queue the offer, send a flit, follow the request.
    function automatic t_ni_result advance_interface(t_ni_cycle c);
        t_ni_result               r;
        nfi_abp_pkg::t_pkt_entry  entry;
        int unsigned              flits;
        r = '{default: '0};
        if (c.pkt_valid) begin
            if (pq_count >= QDEPTH) begin
                r.dropped = 1'b1;
            end else begin
                flits = 32'(c.size);
                if (flits == 0)
                    flits = 1;
                if (flits > nfi_abp_pkg::MAX_PACKET_FLITS)
                    flits = nfi_abp_pkg::MAX_PACKET_FLITS;
                entry.src   = c.src;
                entry.dst   = c.dst;
                entry.stamp = c.stamp;
                entry.size  = nfi_abp_pkg::SIZE_W'(flits);
                pq_store[pq_tail] = entry;
                pq_tail  = (pq_tail + 1) % QDEPTH;
                pq_count = pq_count + 1;
            end
        end
        if (c.ack == tx_lvl && pq_count > 0) begin
            entry        = pq_store[pq_head];
            flits        = 32'(entry.size);
            r.flit_valid = 1'b1;
            r.src        = entry.src;
            r.dst        = entry.dst;
            r.stamp      = entry.stamp;
            r.seq        = nfi_abp_pkg::SEQ_W'(flits_sent);
            if (flits_sent == 0)
                r.kind = nfi_abp_pkg::FLIT_HEAD;
            else if (flits_sent + 1 >= flits)
                r.kind = nfi_abp_pkg::FLIT_TAIL;
            else
                r.kind = nfi_abp_pkg::FLIT_BODY;
            flits_sent = flits_sent + 1;
            if (flits_sent >= flits) begin
                flits_sent = 0;
                pq_head    = (pq_head + 1) % QDEPTH;
                pq_count   = pq_count - 1;
            end
            tx_lvl = ~tx_lvl;
        end
        if (c.req != rx_lvl)
            rx_lvl = c.req;
        r.req_out = tx_lvl;
        r.ack_out = rx_lvl;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            n_errors++;
        end
    endtask

    // Input driver: record the accepted item, then put the next one on the bus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_outputs.push_back(advance_interface(on_bus));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cycles.size() == 0 ||
                             (pending_cycles[0].wait_drain && expected_outputs.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = pending_cycles.pop_front();
                    // The router's level is chosen against the level after all accepted items.
                    case (on_bus.ack_policy)
                        ACK_MATCH:    on_bus.ack = tx_lvl;
                        ACK_MISMATCH: on_bus.ack = ~tx_lvl;
                        default:      ;
                    endcase
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, on_bus.req, on_bus.ack, on_bus.size, on_bus.stamp,
                                 on_bus.dst, on_bus.src};
                    s_tuser  <= on_bus.pkt_valid;
                    n_loaded++;
                end
            end
        end
    end

    // Output monitor: check each result item, then decide the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_gap  = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.src        = m_tdata[7:0];
                got.dst        = m_tdata[15:8];
                got.stamp      = m_tdata[47:16];
                got.seq        = m_tdata[53:48];
                got.req_out    = m_tdata[54];
                got.ack_out    = m_tdata[55];
                got.dropped    = m_tdata[56];
                got.flit_valid = m_tuser[0];
                got.kind       = m_tuser[2:1];
                if (expected_outputs.size() == 0) begin
                    $error("result item arrived with no prediction pending");
                    n_errors++;
                end else begin
                    want = expected_outputs.pop_front();
                    check_field("flit_valid", 32'(want.flit_valid), 32'(got.flit_valid));
                    check_field("flit_src", 32'(want.src), 32'(got.src));
                    check_field("flit_dst", 32'(want.dst), 32'(got.dst));
                    check_field("flit_time", want.stamp, got.stamp);
                    check_field("flit_seq", 32'(want.seq), 32'(got.seq));
                    check_field("flit_kind", 32'(want.kind), 32'(got.kind));
                    check_field("req_out", 32'(want.req_out), 32'(got.req_out));
                    check_field("ack_out", 32'(want.ack_out), 32'(got.ack_out));
                    check_field("pkt_dropped", 32'(want.dropped), 32'(got.dropped));
                end
                n_checked++;
            end
            // One long hold-off so that the block fills up and stalls its input.
            if (!hold_done && n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus, reset and end of test.
    initial begin
        t_ni_cycle   c;
        int unsigned offer_pct;
        int unsigned pick;
        offer_pct = 0;

        // Size zero offered to an empty queue sends a single head flit at once.
        c = quiet_cycle();
        c.pkt_valid  = 1'b1;
        c.ack_policy = ACK_MATCH;
        pending_cycles.push_back(c);

        // Oversized packet with all-ones ids and timestamp; saturates to the longest packet.
        c = quiet_cycle();
        c.pkt_valid  = 1'b1;
        c.src        = '1;
        c.dst        = '1;
        c.stamp      = '1;
        c.size       = '1;
        c.req        = 1'b1;
        c.ack_policy = ACK_MATCH;
        pending_cycles.push_back(c);

        // Fill the queue while the router withholds its acknowledge; the last offer drops.
        for (int k = 0; k < 16; k++) begin
            c = quiet_cycle();
            c.pkt_valid  = 1'b1;
            c.src        = nfi_abp_pkg::ID_W'($urandom);
            c.dst        = nfi_abp_pkg::ID_W'($urandom);
            c.stamp      = $urandom;
            c.size       = (k == 0) ? 7'd1 : (k == 1) ? 7'd64 :
                           nfi_abp_pkg::SIZE_W'($urandom_range(2, 3));
            c.req        = k[0];
            c.ack_policy = ACK_MISMATCH;
            pending_cycles.push_back(c);
        end

        // Offer while full together with a send.
        c = quiet_cycle();
        c.pkt_valid  = 1'b1;
        c.src        = 8'h5a;
        c.size       = 7'd2;
        c.ack_policy = ACK_MATCH;
        pending_cycles.push_back(c);

        // Idle cycles with the raw acknowledge level and a request toggle.
        c = quiet_cycle();
        c.ack = 1'b1;
        c.req = 1'b1;
        pending_cycles.push_back(c);
        c = quiet_cycle();
        c.ack_policy = ACK_MATCH;
        pending_cycles.push_back(c);

        // Random traffic in stretches of varying offer rate.
        for (int i = 0; i < RANDOM_CYCLES; i++) begin
            if (i % 100 == 0)
                offer_pct = $urandom_range(5, 70);
            c = quiet_cycle();
            c.pkt_valid = ($urandom_range(0, 99) < offer_pct);
            c.src       = nfi_abp_pkg::ID_W'($urandom);
            c.dst       = nfi_abp_pkg::ID_W'($urandom);
            c.stamp     = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                c.size = 7'd0;
            else if (pick < 6)
                c.size = 7'd64;
            else if (pick < 9)
                c.size = nfi_abp_pkg::SIZE_W'($urandom_range(65, 127));
            else if (pick < 20)
                c.size = nfi_abp_pkg::SIZE_W'($urandom_range(5, 16));
            else
                c.size = nfi_abp_pkg::SIZE_W'($urandom_range(1, 4));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                c.ack_policy = ACK_MATCH;
            else if (pick < 85)
                c.ack_policy = ACK_MISMATCH;
            else
                c.ack_policy = ACK_AS_GIVEN;
            c.ack        = 1'($urandom_range(0, 1));
            c.req        = 1'($urandom_range(0, 1));
            c.wait_drain = (i == 0 || i == 500);
            pending_cycles.push_back(c);
        end
        n_total = pending_cycles.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/nfi_abp_pkg.sv
sv/noc_flit_injector_abp_core.sv
tb/sv/tb_noc_flit_injector_abp_core.sv
